// ===== rtl/dfr_pkg.sv =====
`default_nettype none

package dfr_pkg;

   localparam int unsigned HDR_BYTES = 36;
   localparam int unsigned POS_W     = 6;

   localparam logic [7:0] VERSION_BYTE = 8'h01;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_STATUS  = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_BAD   = 2'd1;
   localparam logic [1:0] STATUS_SHORT = 2'd2;
   localparam logic [1:0] STATUS_TRUNC = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [31:0] chan;
      logic [31:0] payload_format;
      logic [63:0] time_sent_bits;
      logic [31:0] payload_length;
      logic [7:0]  payload_data;
      logic        payload_last;
      logic [1:0]  status;
      logic        last_of_run;
   } rsp_type;

   // up to two results per accepted byte, written to the queue together
   typedef struct packed {
      logic    valid0;
      logic    valid1;
      rsp_type rsp0;
      rsp_type rsp1;
   } front_push_type;

   // "FSMG"
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] b;
      unique case (idx)
         2'd0: b = 8'h46;
         2'd1: b = 8'h53;
         2'd2: b = 8'h4D;
         2'd3: b = 8'h47;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [31:0] put_lane32(input logic [31:0] word,
                                              input logic [1:0]  lane,
                                              input logic [7:0]  b);
      logic [31:0] r;
      r = word;
      for (int i = 0; i < 4; i++) begin
         if (lane == 2'(i)) r[i*8 +: 8] = b;
      end
      return r;
   endfunction

   function automatic logic [63:0] put_lane64(input logic [63:0] word,
                                              input logic [2:0]  lane,
                                              input logic [7:0]  b);
      logic [63:0] r;
      r = word;
      for (int i = 0; i < 8; i++) begin
         if (lane == 3'(i)) r[i*8 +: 8] = b;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/message_frame_deframer.sv =====
// Datagram deframer. Bytes enter on the req_ channel (push/full), one per
// transfer, with final_byte set on the last byte of a datagram. The 36-byte
// header is checked for "FSMG" and version 1 and its little-endian fields
// are collected; a good header yields one header result, then each payload
// byte up to the declared length yields one payload result, and the final
// byte yields an end status (ok, bad header, short header, truncated).
// Results leave on the rsp_ channel (empty/pop), oldest first.
// Throughput: one byte per cycle while req_full is low; the front decodes
// combinationally and writes up to two results per byte into a
// QUEUE_DEPTH-entry result queue, at the edge that accepts the byte.
// full rises while fewer than two queue entries are free, so a stalled
// receiver backs up into req_full after a few results.
// Reset empties the queue and rearms the header parser; no transfer is
// taken in the reset cycle.
`default_nettype none

module message_frame_deframer #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_push,
   input  dfr_pkg::req_type req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  wire              rsp_pop,
   output dfr_pkg::rsp_type rsp_data
);

   dfr_pkg::front_push_type push;
   logic                    accept;

   assign accept = req_push && !req_full;

   dfr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .push     (push)
   );

   dfr_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/dfr_front.sv =====
`default_nettype none

module dfr_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     accept,
   input  dfr_pkg::req_type        req_data,
   output dfr_pkg::front_push_type push
);

   localparam logic [dfr_pkg::POS_W-1:0] HDR_END = dfr_pkg::POS_W'(dfr_pkg::HDR_BYTES);
   localparam logic [dfr_pkg::POS_W-1:0] HDR_LAST =
      dfr_pkg::POS_W'(dfr_pkg::HDR_BYTES - 1);

   logic [dfr_pkg::POS_W-1:0] pos_ff, pos_in, pos_step;
   logic                      good_ff, good_in, good_step;
   logic [31:0]               seen_ff, seen_in, seen_step;
   logic [31:0]               src_ff, src_in;
   logic [31:0]               dst_ff, dst_in;
   logic [31:0]               chan_ff, chan_in;
   logic [31:0]               fmt_ff, fmt_in;
   logic [63:0]               time_ff, time_in;
   logic [31:0]               len_ff, len_in;

   logic       in_hdr, hdr_hit, pay_hit, fin;
   logic [7:0] b;
   logic [1:0] st;
   dfr_pkg::rsp_type hdr_rsp, pay_rsp, stat_rsp;

   always_comb begin
      b      = req_data.data_byte;
      fin    = req_data.final_byte;
      in_hdr = (pos_ff < HDR_END);

      good_step = good_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      chan_in   = chan_ff;
      fmt_in    = fmt_ff;
      time_in   = time_ff;
      len_in    = len_ff;
      if (in_hdr) begin
         if (pos_ff < 6'd4) begin
            if (b != dfr_pkg::magic_byte(pos_ff[1:0])) good_step = 1'b0;
         end else if (pos_ff == 6'd4) begin
            if (b != dfr_pkg::VERSION_BYTE) good_step = 1'b0;
         end else if (pos_ff >= 6'd8 && pos_ff < 6'd12) begin
            src_in = dfr_pkg::put_lane32(src_ff, pos_ff[1:0], b);
         end else if (pos_ff >= 6'd12 && pos_ff < 6'd16) begin
            dst_in = dfr_pkg::put_lane32(dst_ff, pos_ff[1:0], b);
         end else if (pos_ff >= 6'd16 && pos_ff < 6'd20) begin
            chan_in = dfr_pkg::put_lane32(chan_ff, pos_ff[1:0], b);
         end else if (pos_ff >= 6'd20 && pos_ff < 6'd24) begin
            fmt_in = dfr_pkg::put_lane32(fmt_ff, pos_ff[1:0], b);
         end else if (pos_ff >= 6'd24 && pos_ff < 6'd32) begin
            time_in = dfr_pkg::put_lane64(time_ff, pos_ff[2:0], b);
         end else if (pos_ff >= 6'd32) begin
            len_in = dfr_pkg::put_lane32(len_ff, pos_ff[1:0], b);
         end
      end

      pos_step  = in_hdr ? pos_ff + 6'd1 : pos_ff;
      hdr_hit   = in_hdr && (pos_ff == HDR_LAST) && good_step;
      pay_hit   = !in_hdr && good_ff && (seen_ff < len_ff);
      seen_step = pay_hit ? seen_ff + 32'd1 : seen_ff;

      priority if (pos_step < HDR_END) st = dfr_pkg::STATUS_SHORT;
      else if (!good_step)        st = dfr_pkg::STATUS_BAD;
      else if (seen_step == len_in) st = dfr_pkg::STATUS_OK;
      else                        st = dfr_pkg::STATUS_TRUNC;

      pos_in  = fin ? '0 : pos_step;
      good_in = fin ? 1'b1 : good_step;
      seen_in = fin ? '0 : seen_step;

      hdr_rsp                = '0;
      hdr_rsp.kind           = dfr_pkg::KIND_HEADER;
      hdr_rsp.src_addr       = src_in;
      hdr_rsp.dst_addr       = dst_in;
      hdr_rsp.chan           = chan_in;
      hdr_rsp.payload_format = fmt_in;
      hdr_rsp.time_sent_bits = time_in;
      hdr_rsp.payload_length = len_in;
      hdr_rsp.last_of_run    = !fin;

      pay_rsp              = '0;
      pay_rsp.kind         = dfr_pkg::KIND_PAYLOAD;
      pay_rsp.payload_data = b;
      pay_rsp.payload_last = (seen_step == len_ff);
      pay_rsp.last_of_run  = !fin;

      stat_rsp             = '0;
      stat_rsp.kind        = dfr_pkg::KIND_STATUS;
      stat_rsp.status      = st;
      stat_rsp.last_of_run = 1'b1;

      push.valid0 = accept && (hdr_hit || pay_hit || fin);
      push.valid1 = accept && (hdr_hit || pay_hit) && fin;
      push.rsp0   = hdr_hit ? hdr_rsp : (pay_hit ? pay_rsp : stat_rsp);
      push.rsp1   = stat_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         good_ff <= 1'b1;
         seen_ff <= '0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         good_ff <= good_in;
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         src_ff  <= src_in;
         dst_ff  <= dst_in;
         chan_ff <= chan_in;
         fmt_ff  <= fmt_in;
         time_ff <= time_in;
         len_ff  <= len_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/dfr_queue.sv =====
`default_nettype none

module dfr_queue #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire                     clock,
   input  wire                     reset,
   input  dfr_pkg::front_push_type push,
   output logic                    full,
   output logic                    rsp_empty,
   input  wire                     rsp_pop,
   output dfr_pkg::rsp_type        rsp_data
);

   localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_MARK = CW'(QUEUE_DEPTH - 2);

   dfr_pkg::rsp_type mem_ff [QUEUE_DEPTH];

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0] wr_nxt1, wr_nxt2;
   logic [CW-1:0] count_ff, count_in;
   logic          pop;

   always_comb begin
      pop       = rsp_pop && (count_ff != '0);
      wr_nxt1   = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      wr_nxt2   = (wr_nxt1 == PTR_LAST) ? '0 : wr_nxt1 + 1'b1;
      wr_ptr_in = push.valid1 ? wr_nxt2 : (push.valid0 ? wr_nxt1 : wr_ptr_ff);
      rd_ptr_in = pop ? ((rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + CW'(push.valid0) + CW'(push.valid1) - CW'(pop);
      full      = reset || (count_ff > FULL_MARK);
      rsp_empty = reset || (count_ff == '0);
      rsp_data  = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid0) mem_ff[wr_ptr_ff] <= push.rsp0;
      if (push.valid1) mem_ff[wr_nxt1]   <= push.rsp1;
   end

endmodule

`default_nettype wire

// ===== rtl/dfr_checker.sv =====
`default_nettype none

module dfr_checker (
   input wire              clock,
   input wire              reset,
   input wire              req_push,
   input dfr_pkg::req_type req_data,
   input wire              req_full,
   input wire              rsp_empty,
   input wire              rsp_pop,
   input dfr_pkg::rsp_type rsp_data
);

   // queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // a waiting result is held until popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed before transfer");

   a_kind: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.kind == dfr_pkg::KIND_HEADER ||
                      rsp_data.kind == dfr_pkg::KIND_PAYLOAD ||
                      rsp_data.kind == dfr_pkg::KIND_STATUS))
      else $error("undefined result kind");

   // an end status always closes the run of its byte
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.kind == dfr_pkg::KIND_STATUS) |-> rsp_data.last_of_run)
      else $error("status result without last_of_run");

   // a byte accepted into an empty queue that ends a datagram shows a result next cycle
   a_final_visible: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && req_data.final_byte && rsp_empty) |=> !rsp_empty)
      else $error("final byte produced no result");

endmodule

bind message_frame_deframer dfr_checker u_dfr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_data  (req_data),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== tb/tb_message_frame_deframer.sv =====
`timescale 1ns / 1ps

class frame_scoreboard;
   logic [5:0]       hdr_pos;
   logic             hdr_ok;
   logic [31:0]      src_q;
   logic [31:0]      dst_q;
   logic [31:0]      chan_q;
   logic [31:0]      fmt_q;
   logic [63:0]      time_q;
   logic [31:0]      len_q;
   logic [31:0]      seen_q;
   dfr_pkg::rsp_type expected_q[$];
   int               errors;
   int               checked;

   function new();
      hdr_pos = '0;
      hdr_ok  = 1'b1;
      src_q   = '0;
      dst_q   = '0;
      chan_q  = '0;
      fmt_q   = '0;
      time_q  = '0;
      len_q   = '0;
      seen_q  = '0;
      errors  = 0;
      checked = 0;
   endfunction

   // predicts the results caused by one accepted byte
   function void note_byte(dfr_pkg::req_type item);
      dfr_pkg::rsp_type r;
      dfr_pkg::rsp_type produced[$];
      logic [31:0]      magic;
      int               p;
      magic = "FSMG";
      p = int'(hdr_pos);
      if (hdr_pos < dfr_pkg::HDR_BYTES) begin
         if (p < 4) begin
            if (item.data_byte != magic[8*(3-p) +: 8]) hdr_ok = 1'b0;
         end else if (p == 4) begin
            if (item.data_byte != dfr_pkg::VERSION_BYTE) hdr_ok = 1'b0;
         end else if (p >= 8 && p < 12) begin
            src_q[8*(p-8) +: 8] = item.data_byte;
         end else if (p >= 12 && p < 16) begin
            dst_q[8*(p-12) +: 8] = item.data_byte;
         end else if (p >= 16 && p < 20) begin
            chan_q[8*(p-16) +: 8] = item.data_byte;
         end else if (p >= 20 && p < 24) begin
            fmt_q[8*(p-20) +: 8] = item.data_byte;
         end else if (p >= 24 && p < 32) begin
            time_q[8*(p-24) +: 8] = item.data_byte;
         end else if (p >= 32) begin
            len_q[8*(p-32) +: 8] = item.data_byte;
         end
         hdr_pos = hdr_pos + 6'd1;
         if (hdr_pos == dfr_pkg::HDR_BYTES && hdr_ok) begin
            r = '0;
            r.kind           = dfr_pkg::KIND_HEADER;
            r.src_addr       = src_q;
            r.dst_addr       = dst_q;
            r.chan           = chan_q;
            r.payload_format = fmt_q;
            r.time_sent_bits = time_q;
            r.payload_length = len_q;
            produced = {produced, r};
         end
      end else if (hdr_ok && seen_q < len_q) begin
         r = '0;
         r.kind         = dfr_pkg::KIND_PAYLOAD;
         r.payload_data = item.data_byte;
         r.payload_last = (seen_q + 32'd1 == len_q);
         seen_q = seen_q + 32'd1;
         produced = {produced, r};
      end
      if (item.final_byte) begin
         r = '0;
         r.kind = dfr_pkg::KIND_STATUS;
         if (hdr_pos < dfr_pkg::HDR_BYTES) r.status = dfr_pkg::STATUS_SHORT;
         else if (!hdr_ok) r.status = dfr_pkg::STATUS_BAD;
         else if (seen_q == len_q) r.status = dfr_pkg::STATUS_OK;
         else r.status = dfr_pkg::STATUS_TRUNC;
         produced = {produced, r};
         hdr_pos = '0;
         hdr_ok  = 1'b1;
         seen_q  = '0;
      end
      if (produced.size() > 0) produced[produced.size()-1].last_of_run = 1'b1;
      expected_q = {expected_q, produced};
   endfunction

   task report(string what);
      $display("MISMATCH %s", what);
      errors++;
   endtask

   task compare(string field, logic [63:0] got, logic [63:0] want);
      if (got !== want)
         report($sformatf("result %0d %s: got %0h, expected %0h", checked, field, got, want));
   endtask

   task check_result(dfr_pkg::rsp_type got);
      dfr_pkg::rsp_type want;
      checked++;
      if (expected_q.size() == 0) begin
         report($sformatf("result %0d kind %0d with nothing expected", checked, got.kind));
         return;
      end
      want = expected_q.pop_front();
      compare("kind", got.kind, want.kind);
      compare("src_addr", got.src_addr, want.src_addr);
      compare("dst_addr", got.dst_addr, want.dst_addr);
      compare("chan", got.chan, want.chan);
      compare("payload_format", got.payload_format, want.payload_format);
      compare("time_sent_bits", got.time_sent_bits, want.time_sent_bits);
      compare("payload_length", got.payload_length, want.payload_length);
      compare("payload_data", got.payload_data, want.payload_data);
      compare("payload_last", got.payload_last, want.payload_last);
      compare("status", got.status, want.status);
      compare("last_of_run", got.last_of_run, want.last_of_run);
   endtask
endclass

module tb_message_frame_deframer;
   localparam int IDLE_LIMIT   = 2000;
   localparam int HOLD_CYCLES  = 200;
   localparam int STREAM_BYTES = 520;

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             req_push = 1'b0;
   dfr_pkg::req_type req_data = '0;
   logic             req_full;
   logic             rsp_empty;
   logic             rsp_pop  = 1'b0;
   dfr_pkg::rsp_type rsp_data;

   frame_scoreboard board;
   logic [7:0]      frame_q[$];
   int              bytes_sent    = 0;
   int              idle_cycles   = 0;
   bit              sender_calm   = 1'b0;
   bit              receiver_calm = 1'b0;

   message_frame_deframer dut (
      .clock,
      .reset,
      .req_push,
      .req_data,
      .req_full,
      .rsp_empty,
      .rsp_pop,
      .rsp_data
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      dfr_pkg::req_type item;
      gap = sender_calm ? 0 : $urandom_range(0, 3);
      item.data_byte  = b;
      item.final_byte = fin;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      board.note_byte(item);
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
      frame_q.delete();
   endtask

   task automatic put_header(input bit good, input logic [31:0] length, input int bad_pos);
      logic [31:0] magic;
      logic [31:0] word;
      int          base;
      magic = "FSMG";
      base  = frame_q.size();
      for (int i = 0; i < 4; i++) frame_q = {frame_q, magic[8*(3-i) +: 8]};
      frame_q = {frame_q, dfr_pkg::VERSION_BYTE};
      for (int i = 5; i < 32; i++) frame_q = {frame_q, 8'($urandom)};
      word = length;
      for (int i = 0; i < 4; i++) frame_q = {frame_q, word[8*i +: 8]};
      if (!good)
         frame_q[base + bad_pos] = frame_q[base + bad_pos] ^ 8'($urandom_range(1, 255));
   endtask

   task automatic put_payload(input int count);
      for (int i = 0; i < count; i++) frame_q = {frame_q, 8'($urandom)};
   endtask

   // result side: random stalls, plus one long hold-off so the block backs up
   initial begin
      int wait_cycles;
      bit held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held && board.checked >= 30) begin
            wait_cycles = HOLD_CYCLES;
            held = 1'b1;
         end else begin
            if (board.checked % 20 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
            wait_cycles = receiver_calm ? 0 : $urandom_range(0, 3);
         end
         if (wait_cycles > 0) begin
            rsp_pop <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         board.check_result(rsp_data);
      end
   end

   initial begin
      int          scenario;
      int          count;
      int          frames;
      logic [31:0] len32;
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // short datagrams, including a mismatch that still ends as short
      sender_calm = 1'b1;
      frame_q = '{8'h00};
      send_frame();
      frame_q = '{8'hFF};
      send_frame();
      frame_q = '{8'h46, 8'h53};
      send_frame();
      frame_q = '{8'h00, 8'h53, 8'h4D, 8'h47, 8'h02, 8'hA5};
      send_frame();
      frame_q = '{8'h46, 8'h53, 8'h4D, 8'h47, 8'h01, 8'hFF, 8'h80, 8'h7F};
      send_frame();

      frames = 0;
      while (bytes_sent < STREAM_BYTES) begin
         sender_calm = ($urandom_range(0, 4) == 0);
         scenario = frames % 7;
         frames++;
         case (scenario)
            0: begin
               len32 = $urandom_range(1, 6);
               put_header(1'b1, len32, 0);
               put_payload(int'(len32));
            end
            1: begin
               // header ends on the final byte, no payload
               put_header(1'b1, 32'd0, 0);
            end
            2: begin
               len32 = $urandom_range(0, 4);
               put_header(1'b1, len32, 0);
               put_payload(int'(len32) + $urandom_range(1, 4));
            end
            3: begin
               if ($urandom_range(0, 2) == 0) len32 = '1;
               else if ($urandom_range(0, 1) == 0) len32 = $urandom | 32'd8;
               else len32 = $urandom_range(2, 8);
               put_header(1'b1, len32, 0);
               count = (len32 > 32'd6) ? 5 : int'(len32) - 1;
               put_payload($urandom_range(0, count));
            end
            4: begin
               put_header(1'b0, $urandom_range(0, 4), $urandom_range(0, 4));
               put_payload($urandom_range(0, 5));
            end
            5: begin
               put_header(1'($urandom_range(0, 1)), $urandom_range(0, 4),
                          $urandom_range(0, 4));
               count = $urandom_range(1, 35);
               frame_q = frame_q[0:count-1];
            end
            default: begin
               put_payload($urandom_range(1, 60));
            end
         endcase
         send_frame();
      end
      req_push <= 1'b0;

      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/dfr_pkg.sv
rtl/dfr_front.sv
rtl/dfr_queue.sv
rtl/message_frame_deframer.sv
rtl/dfr_checker.sv
tb/tb_message_frame_deframer.sv
